// ----- rtl/sfla_pkg.sv -----
// Shared types and constants of the segment free-list allocator.
package sfla_pkg;

	localparam int ADDR_W  = 48;
	localparam int BYTES_W = 41;
	localparam int ENTRY_W = ADDR_W + BYTES_W;
	localparam int RESULT_CAP = 64;
	localparam int RESULT_W   = 7;
	localparam int CFG_IDX_W  = 8;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_POOL_BASE  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_POOL_BYTES = 8'd1;

	localparam logic [BYTES_W-1:0] BYTES_MAX = '1;

	typedef enum logic [1:0] {
		ST_GRANTED  = 2'd0,
		ST_FAILED   = 2'd1,
		ST_FREED    = 2'd2,
		ST_OVERFLOW = 2'd3
	} status_t;

endpackage

// ----- rtl/sfla_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module sfla_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/segment_free_list_allocator.sv -----
// Top level of the first-fit segment allocator with coalescing on free.
// Allocate: rounding to the granule, a check, then a table read and a grant per segment.
// Free: a read and a compare per entry walked, a read and a write per entry shifted on insert.
// The table read is registered; the user must keep the granule a power of two (not enforced).
// After reset and after each write to register 0 or 1 the table reloads via S_ROUND, S_LOADW.
// No item is accepted during the reload; a result waiting on the output does not block input.
module segment_free_list_allocator
	import sfla_pkg::*;
#(
	parameter int MAX_SEGMENTS  = 64,
	parameter int GRANULE_BYTES = 2097152
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [ADDR_W-1:0]    cfg_wdata,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// req_bytes, seg_start, seg_bytes
	input  logic [135:0]         s_axis_tdata,
	// opcode
	input  logic [0:0]           s_axis_tuser,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// out_start, out_bytes
	output logic [95:0]          m_axis_tdata,
	// status
	output logic [1:0]           m_axis_tuser,
	output logic                 m_axis_tlast
);

	localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
	localparam int CW = $clog2(MAX_SEGMENTS + 1);
	localparam int SW = CW + 1;
	localparam logic [BYTES_W:0] GMASK = (BYTES_W+1)'(GRANULE_BYTES - 1);
	localparam longint M41 = 64'h1FF_FFFF_FFFF;
	localparam logic [BYTES_W-1:0] CAP_SAT = BYTES_W'(M41 - (M41 % GRANULE_BYTES));

	typedef enum logic [12:0] {
		S_IDLE  = 13'b0000000000001,
		S_ROUND = 13'b0000000000010,
		S_LOADW = 13'b0000000000100,
		S_ACHK  = 13'b0000000001000,
		S_ARD   = 13'b0000000010000,
		S_AWAIT = 13'b0000000100000,
		S_FRD   = 13'b0000001000000,
		S_FCMP  = 13'b0000010000000,
		S_FDEC  = 13'b0000100000000,
		S_SHR   = 13'b0001000000000,
		S_SHW   = 13'b0010000000000,
		S_FINS  = 13'b0100000000000,
		S_RES   = 13'b1000000000000
	} state_t;

	function automatic logic [AW-1:0] phys(input logic [AW-1:0] head, input logic [CW-1:0] l);
		logic [SW-1:0] sum;
		sum = SW'(head) + SW'(l);
		if (sum >= SW'(MAX_SEGMENTS)) begin
			sum = sum - SW'(MAX_SEGMENTS);
		end
		return sum[AW-1:0];
	endfunction

	state_t               state_q;
	logic                 load_q;
	logic [ADDR_W-1:0]    pool_base_q;
	logic [BYTES_W-1:0]   pool_bytes_q;
	logic [BYTES_W-1:0]   req_q;
	logic [ADDR_W-1:0]    seg_start_q;
	logic [BYTES_W-1:0]   seg_bytes_q;
	logic [ADDR_W:0]      end_q;
	logic [BYTES_W:0]     rounded_q;
	logic [BYTES_W-1:0]   need_q;
	logic [BYTES_W-1:0]   unused_q;
	logic [AW-1:0]        head_q;
	logic [CW-1:0]        count_q;
	logic [CW-1:0]        i_q;
	logic [CW-1:0]        pos_q;
	logic [RESULT_W-1:0]  n_q;
	status_t              res_status_q;
	logic                 m_valid_q;
	logic [ADDR_W-1:0]    m_start_q;
	logic [BYTES_W-1:0]   m_bytes_q;
	logic                 m_last_q;
	status_t              m_status_q;

	logic                 ram_we;
	logic [AW-1:0]        ram_waddr;
	logic [ENTRY_W-1:0]   ram_wdata;
	logic [AW-1:0]        ram_raddr;
	logic [ENTRY_W-1:0]   ram_rdata;
	logic [ADDR_W-1:0]    rd_start;
	logic [BYTES_W-1:0]   rd_size;

	logic                 out_free;
	logic                 s_accept;
	logic                 cfg_load;
	logic                 m_load;
	logic                 take_whole;
	logic [BYTES_W-1:0]   round_src;
	logic [BYTES_W:0]     round_sum;
	logic [BYTES_W-1:0]   cap;
	logic [BYTES_W:0]     merged_sum;
	logic [BYTES_W-1:0]   merged;
	logic [BYTES_W:0]     unused_sum;
	logic [BYTES_W-1:0]   unused_add;

	assign rd_start   = ram_rdata[ADDR_W-1:0];
	assign rd_size    = ram_rdata[ENTRY_W-1:ADDR_W];
	assign out_free   = !m_valid_q || m_axis_tready;
	assign s_axis_tready = (state_q == S_IDLE);
	assign s_accept   = s_axis_tvalid && s_axis_tready;
	assign cfg_load   = cfg_we && (cfg_index == REG_POOL_BASE || cfg_index == REG_POOL_BYTES);
	assign m_load     = !cfg_load && out_free && (state_q == S_AWAIT || state_q == S_RES);
	assign take_whole = need_q >= rd_size;
	assign round_src  = load_q ? pool_bytes_q : req_q;
	assign round_sum  = {1'b0, round_src} + GMASK;
	assign cap        = rounded_q[BYTES_W] ? CAP_SAT : rounded_q[BYTES_W-1:0];
	assign merged_sum = {1'b0, rd_size} + {1'b0, seg_bytes_q};
	assign merged     = merged_sum[BYTES_W] ? BYTES_MAX : merged_sum[BYTES_W-1:0];
	assign unused_sum = {1'b0, unused_q} + {1'b0, seg_bytes_q};
	assign unused_add = unused_sum[BYTES_W] ? BYTES_MAX : unused_sum[BYTES_W-1:0];

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {7'd0, m_bytes_q, m_start_q};
	assign m_axis_tuser  = m_status_q;
	assign m_axis_tlast  = m_last_q;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_raddr = '0;
		unique case (state_q)
			S_LOADW: begin
				ram_we    = 1'b1;
				ram_waddr = '0;
				ram_wdata = {cap, pool_base_q};
			end
			S_ARD: begin
				ram_raddr = phys(head_q, '0);
			end
			S_AWAIT: begin
				ram_raddr = phys(head_q, '0);
				ram_waddr = phys(head_q, '0);
				ram_wdata = {rd_size - need_q, rd_start + ADDR_W'(need_q)};
				ram_we    = out_free && !take_whole;
			end
			S_FRD: begin
				ram_raddr = phys(head_q, i_q);
			end
			S_FCMP: begin
				ram_waddr = phys(head_q, i_q);
				ram_wdata = {merged, seg_start_q};
				ram_we    = (end_q == {1'b0, rd_start});
			end
			S_SHR: begin
				ram_raddr = phys(head_q, i_q - CW'(1));
			end
			S_SHW: begin
				ram_we    = 1'b1;
				ram_waddr = phys(head_q, i_q);
				ram_wdata = ram_rdata;
			end
			S_FINS: begin
				ram_we    = 1'b1;
				ram_waddr = phys(head_q, pos_q);
				ram_wdata = {seg_bytes_q, seg_start_q};
			end
			default: begin
			end
		endcase
	end

	sfla_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(MAX_SEGMENTS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_ROUND;
			load_q       <= 1'b1;
			pool_base_q  <= '0;
			pool_bytes_q <= 41'd1073741824;
			head_q       <= '0;
			count_q      <= '0;
			unused_q     <= '0;
			m_valid_q    <= 1'b0;
		end else begin
			m_valid_q <= m_load || (m_valid_q && !m_axis_tready);
			if (cfg_load) begin
				if (cfg_index == REG_POOL_BASE) begin
					pool_base_q <= cfg_wdata;
				end else begin
					pool_bytes_q <= cfg_wdata[BYTES_W-1:0];
				end
				load_q  <= 1'b1;
				state_q <= S_ROUND;
			end else begin
				unique case (state_q)
					S_IDLE: begin
						if (s_accept) begin
							req_q       <= s_axis_tdata[40:0];
							seg_start_q <= s_axis_tdata[88:41];
							seg_bytes_q <= s_axis_tdata[129:89];
							end_q       <= {1'b0, s_axis_tdata[88:41]} +
								(ADDR_W+1)'(s_axis_tdata[129:89]);
							i_q         <= '0;
							pos_q       <= count_q;
							if (s_axis_tuser[0] == OP_ALLOC) begin
								load_q  <= 1'b0;
								state_q <= S_ROUND;
							end else if (count_q == '0) begin
								state_q <= S_FDEC;
							end else begin
								state_q <= S_FRD;
							end
						end
					end
					S_ROUND: begin
						rounded_q <= round_sum & ~GMASK;
						state_q   <= load_q ? S_LOADW : S_ACHK;
					end
					S_LOADW: begin
						head_q   <= '0;
						count_q  <= CW'(1);
						unused_q <= cap;
						state_q  <= S_IDLE;
					end
					S_ACHK: begin
						if (rounded_q == '0 || rounded_q >= {1'b0, unused_q} ||
							count_q == '0) begin
							res_status_q <= ST_FAILED;
							state_q      <= S_RES;
						end else begin
							need_q   <= rounded_q[BYTES_W-1:0];
							unused_q <= unused_q - rounded_q[BYTES_W-1:0];
							n_q      <= '0;
							state_q  <= S_ARD;
						end
					end
					S_ARD: begin
						state_q <= S_AWAIT;
					end
					S_AWAIT: begin
						if (out_free) begin
							m_start_q  <= rd_start;
							m_status_q <= ST_GRANTED;
							n_q        <= n_q + RESULT_W'(1);
							if (take_whole) begin
								m_bytes_q <= rd_size;
								need_q    <= need_q - rd_size;
								head_q    <= phys(head_q, CW'(1));
								count_q   <= count_q - CW'(1);
								if (need_q == rd_size || count_q == CW'(1) ||
									n_q == RESULT_W'(RESULT_CAP - 1)) begin
									m_last_q <= 1'b1;
									state_q  <= S_IDLE;
								end else begin
									m_last_q <= 1'b0;
									state_q  <= S_ARD;
								end
							end else begin
								m_bytes_q <= need_q;
								need_q    <= '0;
								m_last_q  <= 1'b1;
								state_q   <= S_IDLE;
							end
						end
					end
					S_FRD: begin
						state_q <= S_FCMP;
					end
					S_FCMP: begin
						if (end_q == {1'b0, rd_start}) begin
							unused_q     <= unused_add;
							res_status_q <= ST_FREED;
							state_q      <= S_RES;
						end else if (rd_start > seg_start_q) begin
							pos_q   <= i_q;
							state_q <= S_FDEC;
						end else if (i_q + CW'(1) == count_q) begin
							state_q <= S_FDEC;
						end else begin
							i_q     <= i_q + CW'(1);
							state_q <= S_FRD;
						end
					end
					S_FDEC: begin
						if (count_q >= CW'(MAX_SEGMENTS)) begin
							res_status_q <= ST_OVERFLOW;
							state_q      <= S_RES;
						end else if (pos_q == count_q) begin
							state_q <= S_FINS;
						end else begin
							i_q     <= count_q;
							state_q <= S_SHR;
						end
					end
					S_SHR: begin
						state_q <= S_SHW;
					end
					S_SHW: begin
						i_q     <= i_q - CW'(1);
						state_q <= (i_q - CW'(1) == pos_q) ? S_FINS : S_SHR;
					end
					S_FINS: begin
						count_q      <= count_q + CW'(1);
						unused_q     <= unused_add;
						res_status_q <= ST_FREED;
						state_q      <= S_RES;
					end
					S_RES: begin
						if (out_free) begin
							m_start_q  <= '0;
							m_bytes_q  <= '0;
							m_last_q   <= 1'b1;
							m_status_q <= res_status_q;
							state_q    <= S_IDLE;
						end
					end
					default: begin
						state_q <= S_IDLE;
					end
				endcase
			end
		end
	end

endmodule

// ----- rtl/sfla_checker.sv -----
// Port-level assertions for the segment allocator and their bind to the top level.
module sfla_checker
	import sfla_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [ADDR_W-1:0]    cfg_wdata,
	input logic                 s_axis_tvalid,
	input logic                 s_axis_tready,
	input logic [135:0]         s_axis_tdata,
	input logic [0:0]           s_axis_tuser,
	input logic                 m_axis_tvalid,
	input logic                 m_axis_tready,
	input logic [95:0]          m_axis_tdata,
	input logic [1:0]           m_axis_tuser,
	input logic                 m_axis_tlast
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("Stalled output transaction changed.");

	a_status_only: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != ST_GRANTED |-> m_axis_tdata == '0 && m_axis_tlast)
		else $error("Status-only result carries data or lacks last.");

	a_reload_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we && (cfg_index == REG_POOL_BASE || cfg_index == REG_POOL_BYTES)
		|=> !s_axis_tready)
		else $error("Input accepted while the table reloads.");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("Second input transaction taken while one is in work.");

	logic unused_ok;
	assign unused_ok = ^{cfg_wdata, s_axis_tdata, s_axis_tuser};

endmodule

bind segment_free_list_allocator sfla_checker u_sfla_checker (.*);

// ----- test/testbench.sv -----
// Self-checking testbench for the first-fit segment allocator with coalescing on free.
`timescale 1ns / 100ps

module testbench;
	import sfla_pkg::*;

	localparam longint unsigned GRAN   = 64'd2097152;
	localparam longint unsigned MASK41 = 64'h1FF_FFFF_FFFF;
	localparam longint unsigned MASK48 = 64'hFFFF_FFFF_FFFF;
	localparam int NSEG = 64;
	localparam int CYCLE_LIMIT = 1500000;

	typedef struct {
		logic [ADDR_W-1:0]  start;
		logic [BYTES_W-1:0] nbytes;
		logic               last;
		status_t            status;
	} grant_t;

	typedef struct {
		longint unsigned start;
		longint unsigned nbytes;
	} segment_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [ADDR_W-1:0]    cfg_wdata;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [135:0]         s_axis_tdata;
	logic [0:0]           s_axis_tuser;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [95:0]          m_axis_tdata;
	logic [1:0]           m_axis_tuser;
	logic                 m_axis_tlast;

	// Allocator model state.
	longint unsigned base_reg, bytes_reg;
	longint unsigned seg_start_tab[NSEG];
	longint unsigned seg_size_tab[NSEG];
	int              seg_count;
	longint unsigned unused_bytes;

	grant_t   awaited_results[$];
	segment_t granted_segs[$];
	int       errors;
	int       cycles;
	int       idle_pct;
	int       stall_pct;
	int       hold_left;

	segment_free_list_allocator u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint unsigned granule_up(longint unsigned v);
		longint unsigned r;
		r = v % GRAN;
		return (r != 0) ? v + (GRAN - r) : v;
	endfunction

	function automatic void reload_pool();
		longint unsigned cap;
		cap = granule_up(bytes_reg);
		if (cap > MASK41)
			cap = MASK41 - (MASK41 % GRAN);
		foreach (seg_start_tab[i]) begin
			seg_start_tab[i] = 0;
			seg_size_tab[i] = 0;
		end
		seg_start_tab[0] = base_reg & MASK48;
		seg_size_tab[0] = cap;
		seg_count = 1;
		unused_bytes = cap;
	endfunction

	function automatic void push_result(longint unsigned st, longint unsigned nb, bit lst,
			status_t s);
		grant_t g;
		g.start = st[ADDR_W-1:0];
		g.nbytes = nb[BYTES_W-1:0];
		g.last = lst;
		g.status = s;
		awaited_results.push_back(g);
	endfunction

	function automatic void predict_alloc(longint unsigned req);
		longint unsigned size, need, s;
		int n;
		segment_t sg;
		size = granule_up(req & MASK41);
		need = size;
		n = 0;
		if (size == 0 || size >= unused_bytes || seg_count == 0) begin
			push_result(0, 0, 1'b1, ST_FAILED);
			return;
		end
		while (seg_count > 0 && n < RESULT_CAP) begin
			if (need >= seg_size_tab[0]) begin
				s = seg_size_tab[0];
				sg.start = seg_start_tab[0];
				push_result(seg_start_tab[0], s, 1'b0, ST_GRANTED);
				need -= s;
				for (int i = 1; i < seg_count; i++) begin
					seg_start_tab[i-1] = seg_start_tab[i];
					seg_size_tab[i-1] = seg_size_tab[i];
				end
				seg_count--;
				seg_start_tab[seg_count] = 0;
				seg_size_tab[seg_count] = 0;
				sg.nbytes = s;
			end else begin
				sg.start = seg_start_tab[0];
				sg.nbytes = need;
				push_result(seg_start_tab[0], need, 1'b0, ST_GRANTED);
				seg_start_tab[0] = (seg_start_tab[0] + need) & MASK48;
				seg_size_tab[0] -= need;
				need = 0;
			end
			granted_segs.push_back(sg);
			n++;
			if (need == 0)
				break;
		end
		awaited_results[awaited_results.size()-1].last = 1'b1;
		unused_bytes -= size;
	endfunction

	function automatic void predict_free(longint unsigned st, longint unsigned nb);
		longint unsigned seg_end, s;
		int pos;
		seg_end = st + nb;
		pos = seg_count;
		for (int i = 0; i < seg_count; i++) begin
			if (seg_end == seg_start_tab[i]) begin
				s = seg_size_tab[i] + nb;
				seg_start_tab[i] = st;
				seg_size_tab[i] = (s > MASK41) ? MASK41 : s;
				unused_bytes = (unused_bytes + nb > MASK41) ? MASK41 : unused_bytes + nb;
				push_result(0, 0, 1'b1, ST_FREED);
				return;
			end
			if (seg_start_tab[i] > st) begin
				pos = i;
				break;
			end
		end
		if (seg_count >= NSEG) begin
			push_result(0, 0, 1'b1, ST_OVERFLOW);
			return;
		end
		for (int i = seg_count; i > pos; i--) begin
			seg_start_tab[i] = seg_start_tab[i-1];
			seg_size_tab[i] = seg_size_tab[i-1];
		end
		seg_start_tab[pos] = st;
		seg_size_tab[pos] = nb;
		seg_count++;
		unused_bytes = (unused_bytes + nb > MASK41) ? MASK41 : unused_bytes + nb;
		push_result(0, 0, 1'b1, ST_FREED);
	endfunction

	task automatic send_item(logic op, longint unsigned req, longint unsigned st,
			longint unsigned nb);
		if ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(6, 1)) @(negedge clk);
		end else
			@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= {6'd0, nb[BYTES_W-1:0], st[ADDR_W-1:0], req[BYTES_W-1:0]};
		do @(posedge clk); while (!s_axis_tready);
		if (op == OP_ALLOC)
			predict_alloc(req & MASK41);
		else
			predict_free(st & MASK48, nb & MASK41);
	endtask

	task automatic alloc_item(longint unsigned req);
		send_item(OP_ALLOC, req, $urandom, $urandom);
	endtask

	task automatic free_item(longint unsigned st, longint unsigned nb);
		send_item(OP_FREE, {$urandom, $urandom}, st, nb);
	endtask

	task automatic drain();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint unsigned val);
		drain();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val[ADDR_W-1:0];
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_POOL_BASE) begin
			base_reg = val & MASK48;
			reload_pool();
		end else if (idx == REG_POOL_BYTES) begin
			bytes_reg = val & MASK41;
			reload_pool();
		end
	endtask

	task automatic test_directed();
		idle_pct = 0;
		stall_pct = 0;
		alloc_item(0);
		alloc_item(1);
		alloc_item(MASK41);
		alloc_item(unused_bytes);
		alloc_item(GRAN * 3 + 5);
		free_item(0, GRAN);
		free_item(GRAN * 20, GRAN);
		free_item(MASK48, MASK41);
		free_item(GRAN, GRAN);
		free_item(GRAN * 2, 0);
		alloc_item(GRAN * 10);
		alloc_item(GRAN * 7);
		drain();
	endtask

	task automatic test_config();
		write_reg(REG_POOL_BASE, MASK48);
		alloc_item(GRAN * 2);
		write_reg(REG_POOL_BYTES, 0);
		alloc_item(GRAN);
		alloc_item(1);
		write_reg(REG_POOL_BYTES, MASK41);
		alloc_item(MASK41);
		alloc_item(GRAN * 4);
		write_reg(REG_POOL_BYTES, GRAN * 5 + 1);
		alloc_item(GRAN * 6);
		write_reg(CFG_IDX_W'(2), 64'h1234_5678);
		write_reg('1, MASK48);
		alloc_item(GRAN);
		write_reg(REG_POOL_BASE, 64'h5555_5555_5555);
		write_reg(REG_POOL_BASE, 64'hAAAA_AAAA_AAAA);
		write_reg(REG_POOL_BYTES, 64'h0AA_AAAA_AAAA);
		alloc_item(GRAN);
		write_reg(REG_POOL_BYTES, 64'h155_5555_5555);
		alloc_item(GRAN);
		drain();
	endtask

	// Fills the table with scattered segments until it overflows, then makes one allocation that
	// spans as many segments as one allocation may return.
	task automatic test_table_limits();
		write_reg(REG_POOL_BASE, GRAN * 1000);
		write_reg(REG_POOL_BYTES, GRAN * 4);
		idle_pct = 0;
		stall_pct = 0;
		for (int i = 0; i < 68; i++)
			free_item(GRAN * 2 * i, GRAN);
		alloc_item(GRAN * 66);
		alloc_item(GRAN);
		drain();
	endtask

	// The receiver holds off while items keep arriving, so the block must stall its input.
	task automatic test_backpressure();
		write_reg(REG_POOL_BYTES, 64'd1073741824);
		write_reg(REG_POOL_BASE, 0);
		idle_pct = 0;
		@(posedge clk);
		hold_left = 3000;
		for (int i = 0; i < 12; i++)
			alloc_item(GRAN * $urandom_range(3, 1));
		drain();
	endtask

	task automatic random_phase(int idle, int stall, int count);
		longint unsigned sz, st;
		int k;
		segment_t sg;
		idle_pct = idle;
		stall_pct = stall;
		write_reg(REG_POOL_BASE, {$urandom, $urandom} & MASK48 & ~(GRAN - 1));
		write_reg(REG_POOL_BYTES, GRAN * $urandom_range(200, 40) + $urandom_range(3) * 4096);
		granted_segs.delete();
		for (int i = 0; i < count; i++) begin
			k = $urandom_range(99);
			if (k < 40) begin
				if ($urandom_range(5) == 0)
					sz = GRAN * $urandom_range(60, 20);
				else
					sz = $urandom_range(6) * GRAN + $urandom_range(1) * $urandom_range(GRAN);
				alloc_item(sz);
			end else if (k < 80 && granted_segs.size() != 0) begin
				k = $urandom_range(granted_segs.size() - 1);
				sg = granted_segs[k];
				granted_segs.delete(k);
				free_item(sg.start, sg.nbytes);
			end else if (k < 90) begin
				alloc_item({$urandom, $urandom} & MASK41);
			end else begin
				st = {$urandom, $urandom};
				sz = ($urandom_range(1)) ? {$urandom, $urandom} : GRAN * $urandom_range(4);
				free_item(st & MASK48, sz & MASK41);
			end
		end
		drain();
	endtask

	always @(negedge clk) begin
		if (hold_left > 0) begin
			m_axis_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else
			m_axis_tready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		grant_t exp_r;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (awaited_results.size() == 0) begin
				$display("%0t: unexpected result start=%h bytes=%h last=%b status=%0d",
					$time, m_axis_tdata[47:0], m_axis_tdata[88:48], m_axis_tlast,
					m_axis_tuser);
				errors++;
			end else begin
				exp_r = awaited_results.pop_front();
				if (m_axis_tdata[47:0] !== exp_r.start || m_axis_tdata[88:48] !== exp_r.nbytes
						|| m_axis_tlast !== exp_r.last || m_axis_tuser !== exp_r.status) begin
					$display("%0t: mismatch expected start=%h bytes=%h last=%b status=%0d",
						$time, exp_r.start, exp_r.nbytes, exp_r.last, exp_r.status);
					$display("%0t:          actual   start=%h bytes=%h last=%b status=%0d",
						$time, m_axis_tdata[47:0], m_axis_tdata[88:48], m_axis_tlast,
						m_axis_tuser);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		errors = 0;
		cycles = 0;
		idle_pct = 0;
		stall_pct = 0;
		hold_left = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		m_axis_tready = 1'b0;
		base_reg = 0;
		bytes_reg = 64'd1073741824;
		reload_pool();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_config();
		test_table_limits();
		test_backpressure();
		random_phase(0, 0, 55);
		random_phase(82, 0, 55);
		random_phase(0, 82, 55);
		random_phase(35, 35, 55);

		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
